[sv/sts_pkg.sv]
// package for the source token scanner: modes, kinds, error codes, keyword match
package sts_pkg;

  typedef enum logic [12:0] {
    M_IDLE       = 13'h0001,
    M_IDENT      = 13'h0002,
    M_NUMBER     = 13'h0004,
    M_OP         = 13'h0008,
    M_LINE       = 13'h0010,
    M_BLOCK      = 13'h0020,
    M_BLOCK_STAR = 13'h0040,
    M_CHAR_OPEN  = 13'h0080,
    M_CHAR_ESC   = 13'h0100,
    M_CHAR_CLOSE = 13'h0200,
    M_STRING     = 13'h0400,
    M_STRING_ESC = 13'h0800,
    M_ERROR      = 13'h1000
  } mode_e;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_STRING = 6'd2;
  localparam logic [5:0] K_IDENT  = 6'd3;
  localparam logic [5:0] K_LPAREN  = 6'd4;
  localparam logic [5:0] K_RPAREN  = 6'd5;
  localparam logic [5:0] K_LBRACE  = 6'd6;
  localparam logic [5:0] K_RBRACE  = 6'd7;
  localparam logic [5:0] K_LBRACK  = 6'd8;
  localparam logic [5:0] K_RBRACK  = 6'd9;
  localparam logic [5:0] K_SEMI    = 6'd10;
  localparam logic [5:0] K_COLON   = 6'd11;
  localparam logic [5:0] K_COMMA   = 6'd12;
  localparam logic [5:0] K_DOT     = 6'd13;
  localparam logic [5:0] K_PLUS    = 6'd14;
  localparam logic [5:0] K_MINUS   = 6'd15;
  localparam logic [5:0] K_STAR    = 6'd16;
  localparam logic [5:0] K_SLASH   = 6'd17;
  localparam logic [5:0] K_PERCENT = 6'd18;
  localparam logic [5:0] K_ASSIGN  = 6'd19;
  localparam logic [5:0] K_EQ      = 6'd20;
  localparam logic [5:0] K_ADD_EQ  = 6'd21;
  localparam logic [5:0] K_SUB_EQ  = 6'd22;
  localparam logic [5:0] K_MUL_EQ  = 6'd23;
  localparam logic [5:0] K_DIV_EQ  = 6'd24;
  localparam logic [5:0] K_MOD_EQ  = 6'd25;
  localparam logic [5:0] K_INC     = 6'd26;
  localparam logic [5:0] K_DEC     = 6'd27;
  localparam logic [5:0] K_NE      = 6'd28;
  localparam logic [5:0] K_LT      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_GT      = 6'd31;
  localparam logic [5:0] K_GE      = 6'd32;
  localparam logic [5:0] K_NOT     = 6'd33;
  localparam logic [5:0] K_AMP     = 6'd34;
  localparam logic [5:0] K_AND     = 6'd35;
  localparam logic [5:0] K_OR      = 6'd36;
  localparam logic [5:0] K_ARROW   = 6'd37;
  localparam logic [5:0] K_KW0    = 6'd38;
  localparam logic [5:0] K_ERROR  = 6'd55;

  localparam logic [3:0] E_NONE       = 4'd0;
  localparam logic [3:0] E_BLOCK      = 4'd1;
  localparam logic [3:0] E_CHAR_OPEN  = 4'd2;
  localparam logic [3:0] E_CHAR_ESC   = 4'd3;
  localparam logic [3:0] E_CHAR_CLOSE = 4'd4;
  localparam logic [3:0] E_STRING     = 4'd5;
  localparam logic [3:0] E_STR_ESC    = 4'd6;
  localparam logic [3:0] E_STR_BADESC = 4'd7;
  localparam logic [3:0] E_UNEXPECTED = 4'd8;

  localparam int unsigned KwCount  = 17;
  localparam int unsigned KwMaxLen = 10;

  // keywords packed as up to ten bytes, first byte in the low byte
  typedef logic [KwMaxLen*8-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KwCount] = '{
    80'h6f61636e7566, 80'h6f726965746e69, 80'h657265746361726163,
    80'h6f697a6176, 80'h6573, 80'h6f616e6573, 80'h6f746e6175716e65,
    80'h61726170, 80'h72616e726f746572, 80'h617275747572747365,
    80'h6f6c756e, 80'h65645f6f686e616d6174, 80'h7265686c6f637365,
    80'h6f736163, 80'h7261726170, 80'h7261756e69746e6f63,
    80'h61636166
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd6, 4'd7, 4'd9, 4'd5, 4'd2, 4'd5, 4'd8, 4'd4, 4'd8, 4'd9,
    4'd4, 4'd10, 4'd8, 4'd4, 4'd5, 4'd9, 4'd4
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [62:0] value;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [3:0]  err;
    logic        ovf;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  // decoded escape; bit 8 set when the escape is known
  function automatic logic [8:0] escape_val(input logic [7:0] b);
    logic [8:0] r;
    r = '0;
    case (b)
      8'h6e: r = {1'b1, 8'h0a};
      8'h74: r = {1'b1, 8'h09};
      8'h72: r = {1'b1, 8'h0d};
      8'h30: r = {1'b1, 8'h00};
      8'h5c: r = {1'b1, 8'h5c};
      8'h27: r = {1'b1, 8'h27};
      8'h22: r = {1'b1, 8'h22};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/source_token_scanner.sv]
// source token scanner: byte-stream lexer for a small C-like language
//
// input channel: one source byte per beat on src_byte_i; a zero byte ends
// the source, emits an eof token and returns the scanner to its reset state.
// output channel: token beats, each field on its own port; last_o marks the
// final token caused by one input byte. One byte causes zero, one or two
// tokens (a token that ends only when the next byte is seen, or an error, then
// a token, error or eof caused by that byte).
// a token is registered and appears in the cycle after the byte completing it.
// throughput: one byte per cycle; the scanner state and the token for each
// byte are computed in a single pass from the byte. The input stalls only
// while the second token of a two-token byte drains or while the receiver
// stalls.
// reset: clears mode, position counters and the output queue; the identifier
// buffer holds no reset value and is only read where written.
// receiver stall: up to two pending tokens sit in the output queue; the input
// is stalled whenever the queue cannot take a byte's worth of tokens.
module source_token_scanner #(
  parameter int unsigned KEYWORD_BUF_LEN = 10,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        src_byte_valid_i,
  output logic        src_byte_stall_o,
  input  logic [7:0]  src_byte_i,
  output logic        tok_valid_o,
  input  logic        tok_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [62:0] value_o,
  output logic [15:0] token_length_o,
  output logic [15:0] first_line_o,
  output logic [15:0] first_col_o,
  output logic [3:0]  error_code_o,
  output logic        overflow_o,
  output logic        last_o
);
  import sts_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [62:0] ValMax = '1;
  localparam logic [62:0] ValLim = ValMax / 63'd10;  // above this a digit overflows
  localparam int unsigned BufIdx = $clog2(KEYWORD_BUF_LEN);

  // scanner state
  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] tline_q, tline_d, tcol_q, tcol_d;
  logic [15:0]              tlen_q, tlen_d;
  logic [62:0]              acc_q, acc_d;
  logic                     ovf_q, ovf_d;
  logic [7:0]               pend_q, pend_d;
  logic [7:0]               ibuf_q [KEYWORD_BUF_LEN];
  logic                     ibuf_we;
  logic [BufIdx-1:0]        ibuf_wa;
  logic [7:0]               ibuf_wd;

  // two-entry output queue, entry 0 at the head
  tok_t       oq_q [2];
  logic [1:0] olast_q;
  logic [1:0] ocnt_q;

  // per-byte results
  tok_t       r0, r1;
  logic [1:0] rn;

  logic acc_in;
  logic [7:0] b;
  assign b = src_byte_i;

  // output queue only takes a byte when both slots can drain into place
  logic pop;
  assign tok_valid_o = ocnt_q != 2'd0;
  assign pop = tok_valid_o && !tok_stall_i;
  assign src_byte_stall_o = (ocnt_q == 2'd2) || (ocnt_q == 2'd1 && !pop);
  assign acc_in = src_byte_valid_i && !src_byte_stall_o;

  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  // keyword match against the identifier buffer plus length
  logic [5:0] ident_kind;
  always_comb begin
    logic hit;
    ident_kind = K_IDENT;
    for (int k = KwCount - 1; k >= 0; k--) begin
      hit = tlen_q == 16'(KW_LEN[k]);
      for (int j = 0; j < KwMaxLen; j++) begin
        if (j < KW_LEN[k] && j < KEYWORD_BUF_LEN) begin
          if (ibuf_q[j] != KW_TEXT[k][j*8 +: 8]) hit = 1'b0;
        end
      end
      if (hit) ident_kind = K_KW0 + 6'(k);
    end
  end

  // digit accumulate: x*10 plus the digit, saturating
  logic [62:0] acc_next;
  logic        acc_sat;
  always_comb begin
    logic [66:0] t;
    logic [3:0]  d;
    d = 4'(b - 8'h30);
    t = {4'b0, acc_q} * 67'd10 + 67'(d);
    acc_sat  = (acc_q > ValLim) || (t > 67'(ValMax));
    acc_next = acc_sat ? ValMax : t[62:0];
  end

  always_comb begin
    tok_t t;
    logic       do_idle;
    logic [5:0] two, one;
    logic [8:0] esc;
    logic [15:0] tlen_inc;
    mode_d  = mode_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    tlen_d  = tlen_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    pend_d  = pend_q;
    ibuf_we = 1'b0;
    ibuf_wa = '0;
    ibuf_wd = b;
    r0 = '0;
    r1 = '0;
    rn = 2'd0;
    do_idle = 1'b0;
    two = '0;
    one = '0;
    esc = escape_val(b);
    tlen_inc = (tlen_q != 16'hffff) ? tlen_q + 16'd1 : tlen_q;
    t = '0;
    t.line = pos16(tline_q);
    t.col  = pos16(tcol_q);

    unique case (mode_q)
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (tlen_q < 16'(KEYWORD_BUF_LEN)) begin
            ibuf_we = 1'b1;
            ibuf_wa = tlen_q[BufIdx-1:0];
          end
          tlen_d = tlen_inc;
        end else begin
          t.kind = (tlen_q <= 16'(KEYWORD_BUF_LEN)) ? ident_kind : K_IDENT;
          t.len  = tlen_q;
          r0 = t; rn = 2'd1;
          do_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          acc_d = acc_next;
          if (acc_sat) ovf_d = 1'b1;
          tlen_d = tlen_inc;
        end else begin
          t.kind = K_INT; t.value = acc_q; t.len = tlen_q; t.ovf = ovf_q;
          r0 = t; rn = 2'd1;
          do_idle = 1'b1;
        end
      end
      M_OP: begin
        case (pend_q)
          8'h2b: begin
            two = b == 8'h2b ? K_INC : b == 8'h3d ? K_ADD_EQ : 6'd0;
            one = K_PLUS;
          end
          8'h2d: begin
            two = b == 8'h3e ? K_ARROW : b == 8'h2d ? K_DEC : b == 8'h3d ? K_SUB_EQ : 6'd0;
            one = K_MINUS;
          end
          8'h2a: begin two = b == 8'h3d ? K_MUL_EQ : 6'd0; one = K_STAR; end
          8'h2f: begin two = b == 8'h3d ? K_DIV_EQ : 6'd0; one = K_SLASH; end
          8'h25: begin two = b == 8'h3d ? K_MOD_EQ : 6'd0; one = K_PERCENT; end
          8'h3d: begin two = b == 8'h3d ? K_EQ : 6'd0; one = K_ASSIGN; end
          8'h21: begin two = b == 8'h3d ? K_NE : 6'd0; one = K_NOT; end
          8'h3c: begin two = b == 8'h3d ? K_LE : 6'd0; one = K_LT; end
          8'h3e: begin two = b == 8'h3d ? K_GE : 6'd0; one = K_GT; end
          8'h26: begin two = b == 8'h26 ? K_AND : 6'd0; one = K_AMP; end
          8'h7c: begin two = b == 8'h7c ? K_OR : 6'd0; one = 6'd0; end
          default: begin two = 6'd0; one = 6'd0; end
        endcase
        if (pend_q == 8'h2f && b == 8'h2f) begin
          mode_d = M_LINE;
        end else if (pend_q == 8'h2f && b == 8'h2a) begin
          mode_d = M_BLOCK;
        end else if (two != 6'd0) begin
          t.kind = two; t.len = 16'd2;
          r0 = t; rn = 2'd1;
          mode_d = M_IDLE;
        end else if (one == 6'd0) begin
          t.kind = K_ERROR; t.err = E_UNEXPECTED;
          r0 = t; rn = 2'd1;
          mode_d = M_ERROR;
        end else begin
          t.kind = one; t.len = 16'd1;
          r0 = t; rn = 2'd1;
          do_idle = 1'b1;
        end
      end
      M_LINE: begin
        if (b == 8'h0a || b == 8'h00) do_idle = 1'b1;
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (b == 8'h00) begin
          t.kind = K_ERROR; t.err = E_BLOCK;
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else if (b == 8'h2a) mode_d = M_BLOCK_STAR;
        else if (b == 8'h2f && mode_q == M_BLOCK_STAR) mode_d = M_IDLE;
        else mode_d = M_BLOCK;
      end
      M_CHAR_OPEN: begin
        if (b == 8'h00 || b == 8'h0a) begin
          t.kind = K_ERROR; t.err = E_CHAR_OPEN;
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else if (b == 8'h5c) begin
          tlen_d = tlen_inc; mode_d = M_CHAR_ESC;
        end else begin
          pend_d = b; tlen_d = tlen_inc; mode_d = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (!esc[8]) begin
          t.kind = K_ERROR; t.err = E_CHAR_ESC;
          t.line = pos16(line_q); t.col = pos16(col_q);
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else begin
          pend_d = esc[7:0]; tlen_d = tlen_inc; mode_d = M_CHAR_CLOSE;
        end
      end
      M_CHAR_CLOSE: begin
        if (b == 8'h27) begin
          tlen_d = tlen_inc;
          t.kind = K_INT; t.value = 63'(pend_q); t.len = tlen_inc;
          r0 = t; rn = 2'd1; mode_d = M_IDLE;
        end else begin
          t.kind = K_ERROR; t.err = E_CHAR_CLOSE;
          t.line = pos16(line_q); t.col = pos16(col_q);
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end
      end
      M_STRING: begin
        if (b == 8'h00 || b == 8'h0a) begin
          t.kind = K_ERROR; t.err = E_STRING;
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else begin
          tlen_d = tlen_inc;
          if (b == 8'h22) begin
            t.kind = K_STRING; t.len = tlen_inc;
            r0 = t; rn = 2'd1; mode_d = M_IDLE;
          end else if (b == 8'h5c) mode_d = M_STRING_ESC;
        end
      end
      M_STRING_ESC: begin
        if (b == 8'h00 || b == 8'h0a) begin
          t.kind = K_ERROR; t.err = E_STR_ESC;
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else if (!esc[8]) begin
          t.kind = K_ERROR; t.err = E_STR_BADESC;
          t.line = pos16(line_q); t.col = pos16(col_q);
          r0 = t; rn = 2'd1; mode_d = M_ERROR;
        end else begin
          tlen_d = tlen_inc; mode_d = M_STRING;
        end
      end
      M_ERROR: mode_d = M_ERROR;
      default: do_idle = 1'b1;
    endcase

    // idle handling of the current byte, possibly after a finished token
    if (do_idle) begin
      tok_t u;
      u = '0;
      u.line = pos16(line_q);
      u.col  = pos16(col_q);
      mode_d = M_IDLE;
      if (b == 8'h00) begin
        u.kind = K_EOF;
      end else if (is_space(b)) begin
        u.kind = K_EOF;
      end else if (is_alpha(b)) begin
        mode_d = M_IDENT; tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
        ibuf_we = 1'b1; ibuf_wa = '0;
      end else if (is_digit(b)) begin
        mode_d = M_NUMBER; tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
        acc_d = 63'(b - 8'h30); ovf_d = 1'b0;
      end else if (b == 8'h27) begin
        mode_d = M_CHAR_OPEN; tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
      end else if (b == 8'h22) begin
        mode_d = M_STRING; tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
      end else begin
        tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
        u.len = 16'd1;
        case (b)
          8'h28: u.kind = K_LPAREN;
          8'h29: u.kind = K_RPAREN;
          8'h7b: u.kind = K_LBRACE;
          8'h7d: u.kind = K_RBRACE;
          8'h5b: u.kind = K_LBRACK;
          8'h5d: u.kind = K_RBRACK;
          8'h3b: u.kind = K_SEMI;
          8'h3a: u.kind = K_COLON;
          8'h2c: u.kind = K_COMMA;
          8'h2e: u.kind = K_DOT;
          8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h3d, 8'h21, 8'h3c, 8'h3e,
          8'h26, 8'h7c: begin
            mode_d = M_OP; pend_d = b; u.kind = K_EOF;
          end
          default: begin
            u.kind = K_ERROR; u.err = E_UNEXPECTED; u.len = 16'd0;
            mode_d = M_ERROR;
          end
        endcase
      end
      // idle path emits when eof, a one-byte punctuation token or an error
      if (b == 8'h00 || (u.kind != K_EOF)) begin
        if (rn == 2'd0) begin r0 = u; rn = 2'd1; end
        else begin r1 = u; rn = 2'd2; end
      end
    end

    // end of source: eof if not already given, then back to reset state
    if (b == 8'h00) begin
      if (!do_idle) begin
        t = '0; t.kind = K_EOF;
        t.line = pos16(line_q); t.col = pos16(col_q);
        if (rn == 2'd0) begin r0 = t; rn = 2'd1; end
        else begin r1 = t; rn = 2'd2; end
      end
      mode_d = M_IDLE; tline_d = PosOne; tcol_d = PosOne; tlen_d = '0;
      acc_d = '0; ovf_d = 1'b0; pend_d = '0;
      line_d = PosOne; col_d = PosOne;
    end else if (b == 8'h0a) begin
      line_d = (line_q != PosMax) ? line_q + PosOne : line_q;
      col_d  = PosOne;
    end else begin
      line_d = line_q;
      col_d  = (col_q != PosMax) ? col_q + PosOne : col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= PosOne;
      col_q   <= PosOne;
      tline_q <= PosOne;
      tcol_q  <= PosOne;
      tlen_q  <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= '0;
    end else if (acc_in) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      tlen_q  <= tlen_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
    end
  end

  // identifier buffer, no reset
  always_ff @(posedge clk_i) begin
    if (acc_in && ibuf_we) ibuf_q[ibuf_wa] <= ibuf_wd;
  end

  // output queue: shift on pop, append the byte's tokens behind what stays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q  <= 2'd0;
      olast_q <= '0;
    end else begin
      logic [1:0] keep;
      keep = ocnt_q - {1'b0, pop};
      if (acc_in && rn != 2'd0) begin
        if (keep == 2'd0) begin
          olast_q <= (rn == 2'd2) ? 2'b10 : 2'b01;
        end else begin
          olast_q <= {1'b1, olast_q[1]};
        end
        ocnt_q <= keep + rn;
      end else begin
        if (pop) olast_q <= {1'b0, olast_q[1]};
        ocnt_q <= keep;
      end
    end
  end

  // a byte is only taken when the queue empties this cycle, so it loads from the head
  always_ff @(posedge clk_i) begin
    if (acc_in && rn != 2'd0) begin
      oq_q[0] <= r0;
      oq_q[1] <= r1;
    end else if (pop) begin
      oq_q[0] <= oq_q[1];
    end
  end

  assign token_kind_o   = oq_q[0].kind;
  assign value_o        = oq_q[0].value;
  assign token_length_o = oq_q[0].len;
  assign first_line_o   = oq_q[0].line;
  assign first_col_o    = oq_q[0].col;
  assign error_code_o   = oq_q[0].err;
  assign overflow_o     = oq_q[0].ovf;
  assign last_o         = olast_q[0];

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) ocnt_q != 2'd3)
    else $error("output queue overfilled");
  // an error token always carries a code, other tokens carry none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_o |-> ((token_kind_o == K_ERROR) == (error_code_o != E_NONE)))
    else $error("error code mismatch");
  // a zero byte always leaves the scanner idle at line one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && src_byte_i == 8'h00) |=> (mode_q == M_IDLE && line_q == PosOne))
    else $error("end of source did not restart");
  // two queued tokens: the head is never last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q == 2'd2) |-> !olast_q[0])
    else $error("head marked last with a token behind it");

endmodule

[sim/tb.sv]
// testbench for the source token scanner: byte driver, token monitor, scoreboard
`timescale 1ns / 100ps

module tb;
  import sts_pkg::*;

  typedef struct packed {
    logic [5:0]  kind;
    logic [62:0] value;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [3:0]  err;
    logic        ovf;
    logic        last;
  } exp_tok_t;

  localparam logic [62:0] VAL_MAX = {63{1'b1}};
  localparam int unsigned IDENT_BUF = 10;

  logic        clk_i, rst_ni;
  logic        src_byte_valid_i, src_byte_stall_o;
  logic [7:0]  src_byte_i;
  logic        tok_valid_o, tok_stall_i;
  logic [5:0]  token_kind_o;
  logic [62:0] value_o;
  logic [15:0] token_length_o, first_line_o, first_col_o;
  logic [3:0]  error_code_o;
  logic        overflow_o, last_o;

  source_token_scanner dut (
    .clk_i, .rst_ni, .src_byte_valid_i, .src_byte_stall_o, .src_byte_i,
    .tok_valid_o, .tok_stall_i, .token_kind_o, .value_o, .token_length_o,
    .first_line_o, .first_col_o, .error_code_o, .overflow_o, .last_o
  );

  // pending source bytes and expected tokens
  logic [7:0] byte_q[$];
  exp_tok_t   token_q[$];
  int         errors;
  int         sent_bytes, seen_tokens;
  int         send_idle_pct, recv_stall_pct;
  bit         hold_recv;
  bit         hold_send;

  // predictor state
  mode_e       sc_mode;
  logic [15:0] sc_line, sc_col, sc_tline, sc_tcol, sc_len;
  logic [62:0] sc_acc;
  logic        sc_ovf;
  logic [7:0]  sc_pend;
  logic [7:0]  sc_ibuf [IDENT_BUF];
  exp_tok_t    step_toks[$];
  bit          step_eof;

  function automatic bit alpha_b(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit digit_b(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // escape decode, -1 when unknown
  function automatic int esc_code(logic [7:0] b);
    case (b)
      "n": return 10;
      "t": return 9;
      "r": return 13;
      "0": return 0;
      "\\": return 92;
      "'": return 39;
      "\"": return 34;
      default: return -1;
    endcase
  endfunction

  task automatic scan_reset();
    sc_mode = M_IDLE;
    sc_line = 1; sc_col = 1; sc_tline = 1; sc_tcol = 1;
    sc_len = 0; sc_acc = 0; sc_ovf = 0; sc_pend = 0;
  endtask

  task automatic push_tok(logic [5:0] k, logic [62:0] v, logic [15:0] l,
                          logic [15:0] ln, logic [15:0] cl, logic [3:0] e, logic o);
    exp_tok_t t;
    if (step_toks.size() >= 2) return;
    t = '{kind: k, value: v, len: l, line: ln, col: cl, err: e, ovf: o, last: 1'b0};
    step_toks.push_back(t);
  endtask

  task automatic tok_err(logic [3:0] code, logic [15:0] ln, logic [15:0] cl);
    push_tok(K_ERROR, 0, 0, ln, cl, code, 0);
    sc_mode = M_ERROR;
  endtask

  task automatic start_tok(mode_e m);
    sc_mode = m; sc_tline = sc_line; sc_tcol = sc_col; sc_len = 1;
  endtask

  task automatic len_up();
    if (sc_len != 16'hffff) sc_len++;
  endtask

  task automatic ident_done();
    logic [5:0] k;
    bit hit;
    k = K_IDENT;
    if (sc_len <= IDENT_BUF) begin
      for (int i = 0; i < KwCount; i++) begin
        if (KW_LEN[i] == sc_len && k == K_IDENT) begin
          hit = 1;
          for (int j = 0; j < KW_LEN[i]; j++)
            if (KW_TEXT[i][j*8 +: 8] != sc_ibuf[j]) hit = 0;
          if (hit) k = K_KW0 + 6'(i);
        end
      end
    end
    push_tok(k, 0, sc_len, sc_tline, sc_tcol, E_NONE, 0);
  endtask

  task automatic single_op(logic [5:0] k);
    push_tok(k, 0, 1, sc_tline, sc_tcol, E_NONE, 0);
  endtask

  task automatic idle_in(logic [7:0] b);
    sc_mode = M_IDLE;
    if (b == 0) begin
      push_tok(K_EOF, 0, 0, sc_line, sc_col, E_NONE, 0);
      step_eof = 1;
      return;
    end
    if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a) return;
    if (alpha_b(b)) begin
      start_tok(M_IDENT); sc_ibuf[0] = b; return;
    end
    if (digit_b(b)) begin
      start_tok(M_NUMBER); sc_acc = 63'(b - "0"); sc_ovf = 0; return;
    end
    if (b == "'") begin start_tok(M_CHAR_OPEN); return; end
    if (b == "\"") begin start_tok(M_STRING); return; end
    start_tok(M_IDLE);
    case (b)
      "(": single_op(K_LPAREN);
      ")": single_op(K_RPAREN);
      "{": single_op(K_LBRACE);
      "}": single_op(K_RBRACE);
      "[": single_op(K_LBRACK);
      "]": single_op(K_RBRACK);
      ";": single_op(K_SEMI);
      ":": single_op(K_COLON);
      ",": single_op(K_COMMA);
      ".": single_op(K_DOT);
      "+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|": begin
        sc_mode = M_OP; sc_pend = b;
      end
      default: tok_err(E_UNEXPECTED, sc_tline, sc_tcol);
    endcase
  endtask

  task automatic op_in(logic [7:0] b);
    logic [5:0] two, one;
    two = 6'd0; one = 6'd0;
    case (sc_pend)
      "+": begin two = b == "+" ? K_INC : b == "=" ? K_ADD_EQ : 6'd0; one = K_PLUS; end
      "-": begin
        two = b == ">" ? K_ARROW : b == "-" ? K_DEC : b == "=" ? K_SUB_EQ : 6'd0;
        one = K_MINUS;
      end
      "*": begin two = b == "=" ? K_MUL_EQ : 6'd0; one = K_STAR; end
      "/": begin
        if (b == "/") begin sc_mode = M_LINE; return; end
        if (b == "*") begin sc_mode = M_BLOCK; return; end
        two = b == "=" ? K_DIV_EQ : 6'd0; one = K_SLASH;
      end
      "%": begin two = b == "=" ? K_MOD_EQ : 6'd0; one = K_PERCENT; end
      "=": begin two = b == "=" ? K_EQ : 6'd0; one = K_ASSIGN; end
      "!": begin two = b == "=" ? K_NE : 6'd0; one = K_NOT; end
      "<": begin two = b == "=" ? K_LE : 6'd0; one = K_LT; end
      ">": begin two = b == "=" ? K_GE : 6'd0; one = K_GT; end
      "&": begin two = b == "&" ? K_AND : 6'd0; one = K_AMP; end
      "|": begin two = b == "|" ? K_OR : 6'd0; one = 6'd0; end
      default: ;
    endcase
    if (two != 0) begin
      push_tok(two, 0, 2, sc_tline, sc_tcol, E_NONE, 0);
      sc_mode = M_IDLE;
    end else if (one == 0) begin
      tok_err(E_UNEXPECTED, sc_tline, sc_tcol);
    end else begin
      single_op(one);
      idle_in(b);
    end
  endtask

  // predicts the tokens caused by one source byte and queues them
  task automatic scan_byte(logic [7:0] b);
    int e;
    step_toks.delete();
    step_eof = 0;
    case (sc_mode)
      M_IDENT:
        if (alpha_b(b) || digit_b(b)) begin
          if (sc_len < IDENT_BUF) sc_ibuf[sc_len] = b;
          len_up();
        end else begin
          ident_done(); idle_in(b);
        end
      M_NUMBER:
        if (digit_b(b)) begin
          if (sc_acc > (VAL_MAX - 63'(b - "0")) / 10) begin
            sc_acc = VAL_MAX; sc_ovf = 1;
          end else sc_acc = sc_acc * 10 + 63'(b - "0");
          len_up();
        end else begin
          push_tok(K_INT, sc_acc, sc_len, sc_tline, sc_tcol, E_NONE, sc_ovf);
          idle_in(b);
        end
      M_OP: op_in(b);
      M_LINE: if (b == 8'h0a || b == 0) idle_in(b);
      M_BLOCK, M_BLOCK_STAR:
        if (b == 0) tok_err(E_BLOCK, sc_tline, sc_tcol);
        else if (b == "*") sc_mode = M_BLOCK_STAR;
        else if (b == "/" && sc_mode == M_BLOCK_STAR) sc_mode = M_IDLE;
        else sc_mode = M_BLOCK;
      M_CHAR_OPEN:
        if (b == 0 || b == 8'h0a) tok_err(E_CHAR_OPEN, sc_tline, sc_tcol);
        else if (b == "\\") begin len_up(); sc_mode = M_CHAR_ESC; end
        else begin sc_pend = b; len_up(); sc_mode = M_CHAR_CLOSE; end
      M_CHAR_ESC: begin
        e = esc_code(b);
        if (e < 0) tok_err(E_CHAR_ESC, sc_line, sc_col);
        else begin sc_pend = 8'(e); len_up(); sc_mode = M_CHAR_CLOSE; end
      end
      M_CHAR_CLOSE:
        if (b == "'") begin
          len_up();
          push_tok(K_INT, 63'(sc_pend), sc_len, sc_tline, sc_tcol, E_NONE, 0);
          sc_mode = M_IDLE;
        end else tok_err(E_CHAR_CLOSE, sc_line, sc_col);
      M_STRING:
        if (b == 0 || b == 8'h0a) tok_err(E_STRING, sc_tline, sc_tcol);
        else begin
          len_up();
          if (b == "\"") begin
            push_tok(K_STRING, 0, sc_len, sc_tline, sc_tcol, E_NONE, 0);
            sc_mode = M_IDLE;
          end else if (b == "\\") sc_mode = M_STRING_ESC;
        end
      M_STRING_ESC:
        if (b == 0 || b == 8'h0a) tok_err(E_STR_ESC, sc_tline, sc_tcol);
        else if (esc_code(b) < 0) tok_err(E_STR_BADESC, sc_line, sc_col);
        else begin len_up(); sc_mode = M_STRING; end
      M_ERROR: ;
      default: idle_in(b);
    endcase
    if (b == 0) begin
      if (!step_eof) push_tok(K_EOF, 0, 0, sc_line, sc_col, E_NONE, 0);
      scan_reset();
    end else if (b == 8'h0a) begin
      if (sc_line != 16'hffff) sc_line++;
      sc_col = 1;
    end else if (sc_col != 16'hffff) sc_col++;
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  function automatic string pick_word();
    string kws[17] = '{"funcao", "inteiro", "caractere", "vazio", "se", "senao",
      "enquanto", "para", "retornar", "estrutura", "nulo", {"tamanho", "_de"},
      "escolher", "caso", "parar", "continuar", "faca"};
    string lead_set = "aZ_q";
    string tail_set = "aZ_9k0";
    string s;
    int n;
    case ($urandom_range(0, 3))
      0: return kws[$urandom_range(0, 16)];
      1: begin
        s = kws[$urandom_range(0, 16)];
        s = {s, "x"};
        return s;
      end
      default: begin
        s = "";
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++)
          s = {s, string'(i == 0 ? lead_set[$urandom_range(0, 3)]
                                 : tail_set[$urandom_range(0, 5)])};
        return s;
      end
    endcase
  endfunction

  // one well-formed lexeme with random content, or a broken one now and then
  task automatic add_lexeme();
    string ops[23] = '{"(", ")", "{", "}", "[", "]", ";", ":", ",", ".", "+", "-",
      "==", "+=", "-=", "*=", "/=", "%=", "++", "--", "!=", "->", "&&"};
    string esc = "ntr0\\'\"";
    string body_set = "ab c9";
    string s;
    int n;
    case ($urandom_range(0, 11))
      0, 1, 2: add_text(pick_word());
      3: begin
        n = $urandom_range(1, 22);
        for (int i = 0; i < n; i++) byte_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      4: add_text(ops[$urandom_range(0, 22)]);
      5: add_text("<=>=||<>!&%*/=");
      6: begin
        byte_q.push_back("'");
        if ($urandom_range(0, 1)) begin
          byte_q.push_back("\\"); byte_q.push_back(esc[$urandom_range(0, 6)]);
        end else byte_q.push_back(8'($urandom_range(32, 126)));
        byte_q.push_back("'");
      end
      7: begin
        s = "\"";
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
          if ($urandom_range(0, 4) == 0) s = {s, "\\", string'(esc[$urandom_range(0, 6)])};
          else s = {s, string'(body_set[$urandom_range(0, 4)])};
        add_text({s, "\""});
      end
      8: add_text($urandom_range(0, 1) ? "// note x\n" : "/* a * b **/");
      9: byte_q.push_back(8'($urandom_range(1, 255)));
      default: add_text("\n");
    endcase
    byte_q.push_back($urandom_range(0, 2) ? " " : 8'h0a);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || token_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------- clock, reset, limit ----------------
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout with %0d tokens outstanding", token_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_byte_valid_i <= 0;
      src_byte_i <= 0;
    end else begin
      if (src_byte_valid_i && !src_byte_stall_o) begin
        scan_byte(src_byte_i);
        sent_bytes++;
        void'(byte_q.pop_front());
      end
      if (src_byte_valid_i && src_byte_stall_o) begin
        // hold the stalled beat
      end else if (byte_q.size() > 0 && !hold_send &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        src_byte_valid_i <= 1;
        src_byte_i <= byte_q[0];
      end else begin
        src_byte_valid_i <= 0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    exp_tok_t want;
    if (!rst_ni) begin
      tok_stall_i <= 0;
    end else begin
      if (tok_valid_o && !tok_stall_i) begin
        seen_tokens++;
        if (token_q.size() == 0) begin
          $error("token beat with nothing expected, kind %0d", token_kind_o);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (token_kind_o !== want.kind) begin
            $error("token_kind expected %0d got %0d", want.kind, token_kind_o); errors++;
          end
          if (value_o !== want.value) begin
            $error("value expected %0d got %0d", want.value, value_o); errors++;
          end
          if (token_length_o !== want.len) begin
            $error("token_length expected %0d got %0d", want.len, token_length_o); errors++;
          end
          if (first_line_o !== want.line) begin
            $error("first_line expected %0d got %0d", want.line, first_line_o); errors++;
          end
          if (first_col_o !== want.col) begin
            $error("first_col expected %0d got %0d", want.col, first_col_o); errors++;
          end
          if (error_code_o !== want.err) begin
            $error("error_code expected %0d got %0d", want.err, error_code_o); errors++;
          end
          if (overflow_o !== want.ovf) begin
            $error("overflow expected %0d got %0d", want.ovf, overflow_o); errors++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0d got %0d", want.last, last_o); errors++;
          end
        end
      end
      tok_stall_i <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int pcts[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{30, 30}};
    errors = 0; sent_bytes = 0; seen_tokens = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 0; hold_send = 0;
    scan_reset();
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: keywords, extremes, all error kinds, overflow, eof
    add_text({"tamanho", "_de faca estrutura9 x;\n"});
    add_text("inteiro caractere continuar ");
    add_text("9223372036854775807 9223372036854775808 ");
    byte_q.push_back(8'hff); byte_q.push_back(8'h80); byte_q.push_back(0);
    add_text("'\\n''a' \"s\\t\" |x"); byte_q.push_back(0);
    add_text("/* open"); byte_q.push_back(0);
    add_text("'\n"); byte_q.push_back(0);
    add_text("'\\q'"); byte_q.push_back(0);
    add_text("'ab'"); byte_q.push_back(0);
    add_text("\"abc\n"); byte_q.push_back(0);
    add_text("\"a\\"); byte_q.push_back(0);
    add_text("\"a\\z\""); byte_q.push_back(0);
    add_text("a+b>=c// tail"); byte_q.push_back(0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pcts[ph][0];
      recv_stall_pct = pcts[ph][1];
      while (sent_bytes < 200 + ph * 380) begin
        if (byte_q.size() < 8) begin
          add_lexeme();
          if ($urandom_range(0, 40) == 0) byte_q.push_back(0);
        end
        @(posedge clk_i);
      end
      byte_q.push_back(0);
      if (ph == 1) begin
        // receiver holds off while bytes keep coming
        add_text("a ( ) b ; 1 , 2 ");
        hold_recv = 1;
        repeat (60) @(posedge clk_i);
        hold_recv = 0;
      end
      if (ph == 2) begin
        // sender pauses until all tokens are out
        hold_send = 1;
        while (token_q.size() != 0) @(posedge clk_i);
        hold_send = 0;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("sent %0d source bytes, checked %0d tokens", sent_bytes, seen_tokens);
    $display("covered keywords, numbers, literals, comments, errors and stalls");
    if (errors == 0 && token_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
